FILE: design/les_pkg.sv
// Shared types, register indexes and the step program of the Lorenz Euler stepper.
`default_nettype none
package les_pkg;

  // Register indexes on the configuration channel.
  localparam logic [1:0] CFG_SIGMA = 2'd0;
  localparam logic [1:0] CFG_BETA  = 2'd1;
  localparam logic [1:0] CFG_RHO   = 2'd2;

  // Reset values of the coefficients, given in Q11.20.
  localparam longint SIGMA_RST = 64'd10485760;
  localparam longint BETA_RST  = 64'd2796132;
  localparam longint RHO_RST   = 64'd29360128;

  localparam int COLOUR_BITS = 16;
  localparam int PROG_LEN    = 15;

  typedef logic [3:0] pc_t;

  typedef enum logic [1:0] {
    K_ADD,
    K_SUB,
    K_NEG,
    K_MUL
  } kind_t;

  typedef enum logic [3:0] {
    S_X,
    S_Y,
    S_Z,
    S_T,
    S_M,
    S_DX,
    S_DY,
    S_DZ,
    S_SIGMA,
    S_BETA,
    S_RHO,
    S_DT
  } sel_t;

  typedef struct packed {
    kind_t kind;
    sel_t  a;
    sel_t  b;
    sel_t  dst;
  } step_t;

  // One Euler step as a list of saturating operations. The derivatives are all
  // taken from the old point; x, y and z are overwritten only in the last six steps.
  function automatic step_t prog(input pc_t pc);
    step_t s;
    case (pc)
      4'd0:    s = '{K_SUB, S_Y,     S_X,  S_T};
      4'd1:    s = '{K_MUL, S_SIGMA, S_T,  S_DX};
      4'd2:    s = '{K_SUB, S_RHO,   S_Z,  S_T};
      4'd3:    s = '{K_MUL, S_X,     S_T,  S_T};
      4'd4:    s = '{K_SUB, S_T,     S_Y,  S_DY};
      4'd5:    s = '{K_MUL, S_X,     S_Y,  S_M};
      4'd6:    s = '{K_MUL, S_BETA,  S_Z,  S_T};
      4'd7:    s = '{K_NEG, S_T,     S_T,  S_T};
      4'd8:    s = '{K_ADD, S_M,     S_T,  S_DZ};
      4'd9:    s = '{K_MUL, S_DT,    S_DX, S_T};
      4'd10:   s = '{K_ADD, S_X,     S_T,  S_X};
      4'd11:   s = '{K_MUL, S_DT,    S_DY, S_T};
      4'd12:   s = '{K_ADD, S_Y,     S_T,  S_Y};
      4'd13:   s = '{K_MUL, S_DT,    S_DZ, S_T};
      4'd14:   s = '{K_ADD, S_Z,     S_T,  S_Z};
      // A destination of dt writes nothing.
      default: s = '{K_ADD, S_T,     S_T,  S_DT};
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: design/lorenz_euler_step.sv
// Lorenz system stepper: one explicit Euler step per item, with a serial multiplier.
// Each item runs 8 add steps and 7 products on one shift-add multiplier retiring one bit a
// cycle, where the multiplier width MW is WORD_BITS (or FRAC_BITS-9 if larger); then the
// colour lanes are divided out and the result is loaded into the output register. A new
// item is taken only in the idle state, after the last result is loaded; a waiting
// result holds back only the load of the next one. Reset (rst, synchronous) sets x, y
// and z to 1.0 and sigma, beta, rho to 10, 2.6666, 28.
`default_nettype none
module lorenz_euler_step #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // restart
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [((3*WORD_BITS+48+7)/8)*8-1:0] m_tdata,  // x_pos, y_pos, z_pos, red, green, blue
  output logic [0:0]                  m_tuser,   // overflow
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [WORD_BITS-1:0]   cfg_data
);
  import les_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int MW   = (WORD_BITS >= FRAC_BITS - 9) ? WORD_BITS : FRAC_BITS - 9;
  localparam int CNTW = $clog2(MW + 1);
  localparam int CW   = ((WORD_BITS > FRAC_BITS + 8) ? WORD_BITS : FRAC_BITS + 8) + 1;
  localparam int TDW  = ((3*WORD_BITS + 48 + 7) / 8) * 8;

  localparam logic [W-1:0]  MAXV    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINV    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  UNITY   = (FRAC_BITS >= WORD_BITS - 1) ? MAXV
                                                                   : (W'(1) << FRAC_BITS);
  localparam logic [MW-1:0] DT_MAG  = MW'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] FULL    = CW'(200) << FRAC_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_MFIN  = 3'd3;
  localparam logic [2:0] ST_CINIT = 3'd4;
  localparam logic [2:0] ST_COL   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]      state;
  pc_t             pc;
  logic [CNTW-1:0] cnt;
  logic            ovf;

  logic [W-1:0] sigma, beta, rho;
  logic [W-1:0] x, y, z, t, m, dx, dy, dz;

  logic [MW-1:0]   ma;
  logic [2*MW-1:0] prod;
  logic            neg;

  logic [CW-1:0]          rem [3];
  logic [COLOUR_BITS-1:0] quo [3];
  logic                   csat [3];

  step_t           stp;
  logic [W-1:0]    opa, opb;
  logic [W:0]      ea, eb, sum;
  logic            alu_ovf;
  logic [W-1:0]    alu_res;
  logic [MW:0]     hi_sum;
  logic [2*MW-1:0] prod_next;
  logic signed [2*MW-1:0] pw, sh;
  logic [2*MW-W:0] top;
  logic            mul_ovf;
  logic [W-1:0]    mul_res;
  logic            wr_en;
  logic [W-1:0]    wr_val;
  logic [W-1:0]    dlane [3];
  logic [CW-1:0]   lmag [3];
  logic [CW-1:0]   r2 [3];
  logic            ge [3];
  logic [COLOUR_BITS-1:0] col [3];

  function automatic logic [W-1:0] wmag(input logic [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign stp       = prog(pc);

  always_comb begin
    case (stp.a)
      S_X:     opa = x;
      S_Y:     opa = y;
      S_Z:     opa = z;
      S_T:     opa = t;
      S_M:     opa = m;
      S_DX:    opa = dx;
      S_DY:    opa = dy;
      S_DZ:    opa = dz;
      S_SIGMA: opa = sigma;
      S_BETA:  opa = beta;
      S_RHO:   opa = rho;
      default: opa = '0;
    endcase
    case (stp.b)
      S_X:     opb = x;
      S_Y:     opb = y;
      S_Z:     opb = z;
      S_T:     opb = t;
      S_M:     opb = m;
      S_DX:    opb = dx;
      S_DY:    opb = dy;
      S_DZ:    opb = dz;
      S_SIGMA: opb = sigma;
      S_BETA:  opb = beta;
      S_RHO:   opb = rho;
      default: opb = '0;
    endcase
  end

  // Saturating add, subtract and negate, one guard bit wide.
  always_comb begin
    ea = {opa[W-1], opa};
    eb = {opb[W-1], opb};
    unique case (stp.kind)
      K_ADD: sum = ea + eb;
      K_SUB: sum = ea - eb;
      K_NEG: sum = (W+1)'(0) - ea;
      K_MUL: sum = ea;
    endcase
    alu_ovf = (sum[W] != sum[W-1]);
    alu_res = alu_ovf ? (sum[W] ? MINV : MAXV) : sum[W-1:0];
  end

  // Shift-add multiplier on magnitudes: the multiplier bits sit in the low half of
  // prod and leave it one a cycle while the partial sum enters from the top.
  always_comb begin
    hi_sum    = {1'b0, prod[2*MW-1:MW]} + (prod[0] ? {1'b0, ma} : (MW+1)'(0));
    prod_next = {hi_sum, prod[MW-1:1]};
    pw        = neg ? $signed((2*MW)'(0) - prod) : $signed(prod);
    sh        = pw >>> FRAC_BITS;
    top       = sh[2*MW-1:W-1];
    mul_ovf   = !((&top) || !(|top));
    mul_res   = mul_ovf ? (pw[2*MW-1] ? MINV : MAXV) : sh[W-1:0];
  end

  assign wr_en  = ((state == ST_EXEC) && (stp.kind != K_MUL)) || (state == ST_MFIN);
  assign wr_val = (state == ST_MFIN) ? mul_res : alu_res;

  assign dlane[0] = dx;
  assign dlane[1] = dy;
  assign dlane[2] = dz;

  // Colour lanes: restoring division of |d| << 16 by 200.0, one quotient bit a cycle.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lmag[l] = CW'(wmag(dlane[l]));
      r2[l]   = {rem[l][CW-2:0], 1'b0};
      ge[l]   = (r2[l] >= FULL);
      col[l]  = csat[l] ? {COLOUR_BITS{1'b1}} : quo[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= '0;
      cnt      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
      sigma    <= W'(SIGMA_RST);
      beta     <= W'(BETA_RST);
      rho      <= W'(RHO_RST);
      x        <= UNITY;
      y        <= UNITY;
      z        <= UNITY;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SIGMA: sigma <= cfg_data;
          CFG_BETA:  beta  <= cfg_data;
          CFG_RHO:   rho   <= cfg_data;
          default:   ;
        endcase
      end

      // The output state handles its own handshake when it loads a new item.
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end

      if (wr_en) begin
        case (stp.dst)
          S_X:     x  <= wr_val;
          S_Y:     y  <= wr_val;
          S_Z:     z  <= wr_val;
          S_T:     t  <= wr_val;
          S_M:     m  <= wr_val;
          S_DX:    dx <= wr_val;
          S_DY:    dy <= wr_val;
          S_DZ:    dz <= wr_val;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ovf   <= 1'b0;
            pc    <= '0;
            state <= ST_EXEC;
            if (s_tdata[0]) begin
              x <= UNITY;
              y <= UNITY;
              z <= UNITY;
            end
          end
        end
        ST_EXEC: begin
          if (stp.kind == K_MUL) begin
            ma    <= (stp.a == S_DT) ? DT_MAG : MW'(wmag(opa));
            prod  <= {{MW{1'b0}}, MW'(wmag(opb))};
            neg   <= ((stp.a == S_DT) ? 1'b0 : opa[W-1]) ^ opb[W-1];
            cnt   <= '0;
            state <= ST_MUL;
          end else begin
            ovf <= ovf | alu_ovf;
            if (pc == pc_t'(PROG_LEN - 1)) begin
              state <= ST_CINIT;
            end else begin
              pc <= pc + pc_t'(1);
            end
          end
        end
        ST_MUL: begin
          prod <= prod_next;
          cnt  <= cnt + CNTW'(1);
          if (cnt == CNTW'(MW - 1)) begin
            state <= ST_MFIN;
          end
        end
        ST_MFIN: begin
          ovf   <= ovf | mul_ovf;
          pc    <= pc + pc_t'(1);
          state <= ST_EXEC;
        end
        ST_CINIT: begin
          for (int l = 0; l < 3; l++) begin
            rem[l]  <= lmag[l];
            csat[l] <= (lmag[l] >= FULL);
            quo[l]  <= '0;
          end
          cnt   <= '0;
          state <= ST_COL;
        end
        ST_COL: begin
          for (int l = 0; l < 3; l++) begin
            rem[l] <= ge[l] ? (r2[l] - FULL) : r2[l];
            quo[l] <= {quo[l][COLOUR_BITS-2:0], ge[l]};
          end
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(COLOUR_BITS - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= TDW'({col[2], col[1], col[0], z, y, x});
            m_tuser  <= ovf;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The serial multiplier never runs past its last bit.
  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt < CNTW'(MW)))
    else $error("multiplier bit count ran past the operand width");

  // An accepted item always starts the program from its first step.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ((state == ST_EXEC) && (pc == '0)))
    else $error("accepted item did not start at the first step");

  // A result still waiting in the output register is never overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && m_tvalid && !m_tready) |=> (state == ST_OUT))
    else $error("finished result left while the output register was full");

  // The program counter stays inside the program while steps execute.
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC || state == ST_MUL || state == ST_MFIN) |-> (pc < pc_t'(PROG_LEN)))
    else $error("program counter outside the step program");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the Lorenz Euler stepper, with a fixed-point predictor of the expected points.
`default_nettype none
module testbench;
  import les_pkg::*;

  localparam int    W            = 32;
  localparam int    FRAC         = 20;
  localparam longint WMAX        = 64'sd2147483647;
  localparam longint WMIN        = -WMAX - 1;
  localparam longint ONE         = 64'sd1 <<< FRAC;
  localparam longint DT_STEP     = ((64'sd1 <<< FRAC) + 500) / 1000;
  localparam longint COLOUR_FULL = 64'sd200 <<< FRAC;
  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int    RANDOM_ITEMS = 850;
  localparam int    SETTLE_CYCLES = 250;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    logic [W-1:0]  x;
    logic [W-1:0]  y;
    logic [W-1:0]  z;
    logic [15:0]   red;
    logic [15:0]   green;
    logic [15:0]   blue;
    logic          ovf;
  } point_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [1:0]   idx;
    logic [W-1:0] data;
    logic         restart;
    logic         typed;
    point_t       want;
  } row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [7:0]      s_tdata = 8'd0;    // restart
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [143:0]    m_tdata;           // x_pos, y_pos, z_pos, red, green, blue
  logic [0:0]      m_tuser;           // overflow
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [1:0]      cfg_index = 2'd0;
  logic [W-1:0]    cfg_data = '0;

  // Predictor state: the point and the coefficients as the block should hold them.
  longint pos_x, pos_y, pos_z;
  longint coef_sigma, coef_beta, coef_rho;
  bit     sat_hit;

  point_t pending_points[$];
  int     errors = 0;
  longint cycles = 0;
  bit     calm = 1'b0;

  lorenz_euler_step dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_word(longint v);
    if (v > WMAX) begin
      sat_hit = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat_hit = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  // Operands are within the word, so the full product fits in 64 bits; the
  // arithmetic shift gives the floor rounding.
  function automatic longint fx_mul(longint a, longint b);
    return clamp_word((a * b) >>> FRAC);
  endfunction

  function automatic logic [15:0] colour_of(longint d);
    longint m;
    m = (d < 0) ? -d : d;
    if (m >= COLOUR_FULL) return 16'hffff;
    return 16'((m <<< 16) / COLOUR_FULL);
  endfunction

  function automatic point_t lorenz_step(logic restart);
    longint dx, dy, dz;
    point_t p;
    sat_hit = 1'b0;
    if (restart) begin
      pos_x = ONE;
      pos_y = ONE;
      pos_z = ONE;
    end
    dx = fx_mul(coef_sigma, clamp_word(pos_y - pos_x));
    dy = clamp_word(fx_mul(pos_x, clamp_word(coef_rho - pos_z)) - pos_y);
    dz = clamp_word(fx_mul(pos_x, pos_y) + clamp_word(-fx_mul(coef_beta, pos_z)));
    pos_x = clamp_word(pos_x + fx_mul(DT_STEP, dx));
    pos_y = clamp_word(pos_y + fx_mul(DT_STEP, dy));
    pos_z = clamp_word(pos_z + fx_mul(DT_STEP, dz));
    p.x     = W'(pos_x);
    p.y     = W'(pos_y);
    p.z     = W'(pos_z);
    p.red   = colour_of(dx);
    p.green = colour_of(dy);
    p.blue  = colour_of(dz);
    p.ovf   = sat_hit;
    return p;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t item_row(logic restart);
    row_t r;
    r = '0;
    r.kind    = ROW_ITEM;
    r.restart = restart;
    return r;
  endfunction

  function automatic row_t typed_row(logic restart, point_t want);
    row_t r;
    r = item_row(restart);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // Mostly plausible coefficients, now and then an extreme or a wild value.
  function automatic logic [W-1:0] pick_coef(int unsigned top);
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return $urandom;
      4:       return -W'($urandom_range(32'h0100_0000));
      default: return W'($urandom_range(top));
    endcase
  endfunction

  task automatic report(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task automatic send_item(logic restart, logic typed, point_t want);
    point_t p;
    while (!calm && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!s_tready);
    p = lorenz_step(restart);
    pending_points.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [W-1:0] data);
    while ($urandom_range(99) < 21) begin
      cfg_valid <= 1'b0;
      @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SIGMA: coef_sigma = longint'($signed(data));
      CFG_BETA:  coef_beta  = longint'($signed(data));
      CFG_RHO:   coef_rho   = longint'($signed(data));
      default:   ;
    endcase
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected point has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_points.size() == 0) begin
        report("unexpected result", m_tdata[31:0], '0);
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[31:0]    !== want.x)     report("x_pos", m_tdata[31:0], want.x);
        if (m_tdata[63:32]   !== want.y)     report("y_pos", m_tdata[63:32], want.y);
        if (m_tdata[95:64]   !== want.z)     report("z_pos", m_tdata[95:64], want.z);
        if (m_tdata[111:96]  !== want.red)
          report("red", W'(m_tdata[111:96]), W'(want.red));
        if (m_tdata[127:112] !== want.green)
          report("green", W'(m_tdata[127:112]), W'(want.green));
        if (m_tdata[143:128] !== want.blue)
          report("blue", W'(m_tdata[143:128]), W'(want.blue));
        if (m_tuser[0]       !== want.ovf)
          report("overflow", W'(m_tuser[0]), W'(want.ovf));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    row_t   plan[$];
    point_t none;
    bit     streaming;
    int     sent;
    int     run;
    none = '0;
    streaming = 1'b0;
    sent = 0;

    pos_x = ONE;
    pos_y = ONE;
    pos_z = ONE;
    coef_sigma = longint'($signed(W'(SIGMA_RST)));
    coef_beta  = longint'($signed(W'(BETA_RST)));
    coef_rho   = longint'($signed(W'(RHO_RST)));

    // First step from the reset point with the default coefficients.
    plan.push_back(typed_row(1'b0, '{32'd1048576, 32'd1075850, 32'd1046827,
                                     16'd0, 16'd8519, 16'd546, 1'b0}));
    plan.push_back(item_row(1'b0));
    plan.push_back(item_row(1'b0));
    plan.push_back(item_row(1'b0));
    plan.push_back(item_row(1'b1));
    // With sigma and beta zero and rho one, dy is -1 and dz is +1.
    plan.push_back(cfg_row(CFG_SIGMA, 32'd0));
    plan.push_back(cfg_row(CFG_BETA, 32'd0));
    plan.push_back(cfg_row(CFG_RHO, W'(ONE)));
    plan.push_back(typed_row(1'b1, '{32'd1048576, 32'd1047527, 32'd1049625,
                                     16'd0, 16'd327, 16'd327, 1'b0}));
    plan.push_back(item_row(1'b0));
    // Extreme coefficients drive the negation and the sums into saturation.
    plan.push_back(cfg_row(CFG_SIGMA, 32'h7fff_ffff));
    plan.push_back(cfg_row(CFG_BETA, 32'h8000_0000));
    plan.push_back(cfg_row(CFG_RHO, 32'h7fff_ffff));
    plan.push_back(item_row(1'b1));
    plan.push_back(item_row(1'b0));
    plan.push_back(item_row(1'b0));
    plan.push_back(cfg_row(CFG_SIGMA, 32'h8000_0000));
    plan.push_back(cfg_row(CFG_BETA, 32'h7fff_ffff));
    plan.push_back(cfg_row(CFG_RHO, 32'h8000_0000));
    plan.push_back(item_row(1'b1));
    plan.push_back(item_row(1'b0));
    plan.push_back(item_row(1'b0));
    // The unused register index must leave every coefficient alone.
    plan.push_back(cfg_row(CFG_NONE, 32'hffff_ffff));
    plan.push_back(item_row(1'b0));
    plan.push_back(cfg_row(CFG_SIGMA, W'(SIGMA_RST)));
    plan.push_back(cfg_row(CFG_BETA, W'(BETA_RST)));
    plan.push_back(cfg_row(CFG_RHO, W'(RHO_RST)));
    plan.push_back(item_row(1'b1));
    plan.push_back(item_row(1'b0));

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (streaming) begin
          settle();
          streaming = 1'b0;
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (!streaming) begin
          cfg_valid <= 1'b0;
          streaming = 1'b1;
        end
        send_item(plan[i].restart, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: new coefficients while idle, then a run of steps.
    while (sent < RANDOM_ITEMS) begin
      settle();
      write_reg(CFG_SIGMA, pick_coef(16 << FRAC));
      write_reg(CFG_BETA, pick_coef(4 << FRAC));
      write_reg(CFG_RHO, pick_coef(48 << FRAC));
      if ($urandom_range(3) == 0) write_reg(CFG_NONE, $urandom);
      cfg_valid <= 1'b0;
      run = $urandom_range(10, 60);
      for (int k = 0; k < run && sent < RANDOM_ITEMS; k++) begin
        calm = (sent >= 300 && sent < 450);
        send_item((k == 0) ? ($urandom_range(3) != 0) : ($urandom_range(49) == 0),
                  1'b0, none);
        sent++;
      end
    end
    calm = 1'b0;

    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
